/* hw/rtl/fasc_pkg.sv */
// ----------------------------------------------------------------------------
// fasc_pkg
// Shared types, constants and the fuzzy rule base of the slip controller.
// ----------------------------------------------------------------------------
package fasc_pkg;

  localparam int unsigned CfgWidth = 10;
  localparam int unsigned MulWidth = 11;

  localparam logic [1:0] CFG_SLIP_TARGET  = 2'd0;
  localparam logic [1:0] CFG_TICK_PERIOD  = 2'd1;
  localparam logic [1:0] CFG_WHEEL_RADIUS = 2'd2;

  localparam logic [CfgWidth-1:0] RST_SLIP_TARGET  = 10'd150;
  localparam logic [CfgWidth-1:0] RST_TICK_PERIOD  = 10'd20;
  localparam logic [CfgWidth-1:0] RST_WHEEL_RADIUS = 10'd250;

  localparam logic [MulWidth-1:0] K_THOU = 11'd1000;
  localparam logic [MulWidth-1:0] K_ONE  = 11'd1;

  localparam logic signed [10:0] DRIVE_RELEASE = -11'sd1000;

  typedef struct packed {
    logic [2:0]  k;
    logic [10:0] m;
  } seg_t;

  localparam logic signed [11:0] RULE_TAB [7][7] = '{
    '{ 12'sd1000,  12'sd1000,  12'sd1000,  12'sd1000,  12'sd667,   12'sd333,   12'sd0    },
    '{ 12'sd1000,  12'sd1000,  12'sd1000,  12'sd667,   12'sd667,   12'sd0,    -12'sd333  },
    '{ 12'sd1000,  12'sd667,   12'sd667,   12'sd333,   12'sd0,    -12'sd333,  -12'sd667  },
    '{ 12'sd1000,  12'sd667,   12'sd333,   12'sd0,    -12'sd333,  -12'sd667,  -12'sd1000 },
    '{ 12'sd667,   12'sd333,   12'sd0,    -12'sd333,  -12'sd667,  -12'sd667,  -12'sd1000 },
    '{ 12'sd333,   12'sd0,    -12'sd667,  -12'sd667,  -12'sd1000, -12'sd1000, -12'sd1000 },
    '{ 12'sd0,    -12'sd333,  -12'sd667,  -12'sd1000, -12'sd1000, -12'sd1000, -12'sd1000 }
  };

  // Lower active set and its weight; the upper neighbor weighs 1000 - m.
  function automatic seg_t seg_of(input logic signed [11:0] x);
    seg_t s;
    int   xi;
    xi = int'(x);
    if (xi <= -1000) begin
      s.k = 3'd0; s.m = 11'd1000;
    end else if (xi <= -500) begin
      s.k = 3'd0; s.m = 11'(-2 * xi - 1000);
    end else if (xi <= -250) begin
      s.k = 3'd1; s.m = 11'(-4 * xi - 1000);
    end else if (xi <= 0) begin
      s.k = 3'd2; s.m = 11'(-4 * xi);
    end else if (xi <= 250) begin
      s.k = 3'd3; s.m = 11'(1000 - 4 * xi);
    end else if (xi <= 500) begin
      s.k = 3'd4; s.m = 11'(2000 - 4 * xi);
    end else if (xi < 1000) begin
      s.k = 3'd5; s.m = 11'(2000 - 2 * xi);
    end else begin
      s.k = 3'd5; s.m = 11'd0;
    end
    return s;
  endfunction

  function automatic logic signed [11:0] rule_at(input logic [2:0] r, input logic [2:0] c);
    return RULE_TAB[r][c];
  endfunction

endpackage

/* hw/rtl/fasc_muldiv.sv */
// ----------------------------------------------------------------------------
// fasc_muldiv
// Shared serial unit: sign * (a * b), divided by c when div_i is set; one
// multiplier bit, then one quotient bit per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
module fasc_muldiv #(
  parameter int AM = 33,
  parameter int PW = 44
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [AM-1:0]                 a_i,
  input  logic [fasc_pkg::MulWidth-1:0] b_i,
  input  logic [AM-1:0]                 c_i,
  input  logic                          neg_i,
  input  logic                          div_i,
  output logic                          done_o,
  output logic signed [PW:0]            res_o
);
  import fasc_pkg::*;

  localparam int CW = $clog2(PW);
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;

  logic [1:0]          ph_q;
  logic [CW-1:0]       cnt_q;
  logic [PW-1:0]       acc_q;
  logic [PW-1:0]       ash_q;
  logic [MulWidth-1:0] b_q;
  logic [AM-1:0]       c_q;
  logic [AM:0]         rem_q;
  logic                neg_q;
  logic                div_q;
  logic                done_q;
  logic [AM:0]         rem_sh;
  logic [AM:0]         rem_sub;
  logic                fits;

  assign rem_sh  = {rem_q[AM-1:0], acc_q[PW-1]};
  assign rem_sub = rem_sh - {1'b0, c_q};
  assign fits    = rem_sh >= {1'b0, c_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (ph_q)
        PH_IDLE: begin
          if (start_i) begin
            ph_q  <= PH_MUL;
            cnt_q <= '0;
          end
        end
        PH_MUL: begin
          if (cnt_q == CW'(MulWidth - 1)) begin
            cnt_q <= '0;
            if (div_q) begin
              ph_q <= PH_DIV;
            end else begin
              ph_q   <= PH_IDLE;
              done_q <= 1'b1;
            end
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        PH_DIV: begin
          if (cnt_q == CW'(PW - 1)) begin
            ph_q   <= PH_IDLE;
            done_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: begin
          ph_q <= PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (ph_q)
      PH_IDLE: begin
        if (start_i) begin
          acc_q <= '0;
          ash_q <= PW'(a_i);
          b_q   <= b_i;
          c_q   <= c_i;
          neg_q <= neg_i;
          div_q <= div_i;
          rem_q <= '0;
        end
      end
      PH_MUL: begin
        acc_q <= acc_q + (b_q[0] ? ash_q : '0);
        ash_q <= {ash_q[PW-2:0], 1'b0};
        b_q   <= {1'b0, b_q[MulWidth-1:1]};
      end
      PH_DIV: begin
        rem_q <= fits ? rem_sub : rem_sh;
        acc_q <= {acc_q[PW-2:0], fits};
      end
      default: begin
        rem_q <= rem_q;
      end
    endcase
  end

  assign done_o = done_q;
  assign res_o  = neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});

endmodule

/* hw/rtl/fuzzy_abs_slip_controller.sv */
// ----------------------------------------------------------------------------
// fuzzy_abs_slip_controller
// Fuzzy anti-lock brake slip controller, one result per control tick.
// ----------------------------------------------------------------------------
// One input transfer yields one result transfer. Every product and quotient
// runs through a single shared serial multiply/divide unit whose product
// register is PW = max(ACC_WIDTH+1, 31) + 11 bits wide. A released-pedal tick
// takes one operation. A pressed tick takes seven divide operations (six when
// the speed estimate is not above zero) and four multiply-only operations.
// The next input is taken once the result sits in the output register.
module fuzzy_abs_slip_controller #(
  parameter int ACC_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [9:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [17:0]        wheel_speed_i,
  input  logic signed [15:0] vehicle_accel_i,
  input  logic               brake_pressed_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [10:0] modulator_drive_o,
  output logic               speed_fault_o
);
  import fasc_pkg::*;

  localparam int AW = ACC_WIDTH;
  localparam int AM = (AW + 1 > 31) ? AW + 1 : 31;
  localparam int PW = AM + MulWidth;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_WT   = 4'd1;
  localparam logic [3:0] ST_V    = 4'd2;
  localparam logic [3:0] ST_SLIP = 4'd3;
  localparam logic [3:0] ST_RATE = 4'd4;
  localparam logic [3:0] ST_R0A  = 4'd5;
  localparam logic [3:0] ST_R0B  = 4'd6;
  localparam logic [3:0] ST_N0   = 4'd7;
  localparam logic [3:0] ST_R1A  = 4'd8;
  localparam logic [3:0] ST_R1B  = 4'd9;
  localparam logic [3:0] ST_N1   = 4'd10;
  localparam logic [3:0] ST_FIN  = 4'd11;
  localparam logic [3:0] ST_OUT  = 4'd12;

  localparam logic signed [PW:0] RLIM = (PW + 1)'(1000);
  localparam logic signed [32:0] ELIM = 33'sd1000;
  localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW - 1){1'b1}}};
  localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW - 1){1'b0}}};

  logic [CfgWidth-1:0] tgt_q, per_q, rad_q;
  logic [CfgWidth-1:0] per_eff;

  logic [3:0]           st_q;
  logic                 iss_q;
  logic [17:0]          ws_q;
  logic                 prs_q;
  logic signed [AW-1:0] acc_tot_q;
  logic [18:0]          base_q;
  logic [18:0]          w_q;
  logic signed [AM:0]   v_q;
  logic signed [31:0]   slip_q;
  logic signed [31:0]   prev_q;
  logic [2:0]           ka_q, ke_q;
  logic [10:0]          ma_q, me_q;
  logic signed [20:0]   t_q, row_q, n_q;
  logic signed [10:0]   drv_q;
  logic                 flt_q;

  logic                 out_valid_q;
  logic signed [10:0]   out_drv_q;
  logic                 out_flt_q;

  logic                 eng_start, eng_done, eng_neg, eng_div;
  logic [AM-1:0]        eng_a, eng_c;
  logic [MulWidth-1:0]  eng_b;
  logic signed [PW:0]   eng_res;

  logic                 in_xfer;
  logic signed [AW:0]   acc_sum;
  logic signed [AW-1:0] acc_next;
  logic [AW-1:0]        acc_mag;
  logic signed [AM:0]   dvw;
  logic [AM:0]          dvw_mag;
  logic signed [32:0]   dsl;
  logic [32:0]          dsl_mag;
  logic signed [AM:0]   v_new;
  logic signed [32:0]   err_w;
  logic signed [11:0]   err_c, rate_c;
  seg_t                 seg_e, seg_r;
  logic signed [11:0]   rv;
  logic [11:0]          rv_mag;
  logic [20:0]          row_mag, n_mag;
  logic [2:0]           rsel, csel;
  logic                 out_load;

  assign per_eff = (per_q == '0) ? CfgWidth'(1) : per_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q <= RST_SLIP_TARGET;
      per_q <= RST_TICK_PERIOD;
      rad_q <= RST_WHEEL_RADIUS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SLIP_TARGET:  tgt_q <= cfg_wdata_i;
        CFG_TICK_PERIOD:  per_q <= cfg_wdata_i;
        CFG_WHEEL_RADIUS: rad_q <= cfg_wdata_i;
        default: begin
          tgt_q <= tgt_q;
        end
      endcase
    end
  end

  assign in_ready_o = (st_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  assign acc_sum = $signed({acc_tot_q[AW-1], acc_tot_q})
                 + $signed({{(AW - 15){vehicle_accel_i[15]}}, vehicle_accel_i});
  always_comb begin
    if (!brake_pressed_i) begin
      acc_next = $signed({{(AW - 16){vehicle_accel_i[15]}}, vehicle_accel_i});
    end else if (acc_sum[AW] != acc_sum[AW-1]) begin
      acc_next = acc_sum[AW] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_next = acc_sum[AW-1:0];
    end
  end

  assign acc_mag = acc_tot_q[AW-1] ? AW'(-acc_tot_q) : AW'(acc_tot_q);
  assign dvw     = v_q - $signed({{(AM + 1 - 19){1'b0}}, w_q});
  assign dvw_mag = dvw[AM] ? (AM + 1)'(-dvw) : (AM + 1)'(dvw);
  assign dsl     = $signed({slip_q[31], slip_q}) - $signed({prev_q[31], prev_q});
  assign dsl_mag = dsl[32] ? 33'(-dsl) : 33'(dsl);
  assign row_mag = row_q[20] ? 21'(-row_q) : 21'(row_q);
  assign n_mag   = n_q[20] ? 21'(-n_q) : 21'(n_q);
  assign v_new   = eng_res[AM:0] + $signed({{(AM + 1 - 19){1'b0}}, base_q});

  assign err_w = $signed({slip_q[31], slip_q}) - $signed({23'b0, tgt_q});
  always_comb begin
    if (err_w > ELIM) begin
      err_c = 12'sd1000;
    end else if (err_w < -ELIM) begin
      err_c = -12'sd1000;
    end else begin
      err_c = err_w[11:0];
    end
    if (eng_res > RLIM) begin
      rate_c = 12'sd1000;
    end else if (eng_res < -RLIM) begin
      rate_c = -12'sd1000;
    end else begin
      rate_c = eng_res[11:0];
    end
  end
  assign seg_e = seg_of(err_c);
  assign seg_r = seg_of(rate_c);

  assign rsel   = (st_q == ST_R1A || st_q == ST_R1B) ? ke_q + 3'd1 : ke_q;
  assign csel   = (st_q == ST_R0B || st_q == ST_R1B) ? ka_q + 3'd1 : ka_q;
  assign rv     = rule_at(rsel, csel);
  assign rv_mag = rv[11] ? 12'(-rv) : 12'(rv);

  always_comb begin
    eng_a   = '0;
    eng_b   = K_ONE;
    eng_c   = AM'(K_THOU);
    eng_neg = 1'b0;
    eng_div = 1'b1;
    case (st_q)
      ST_WT: begin
        eng_a = AM'(ws_q);
        eng_b = {1'b0, rad_q};
      end
      ST_V: begin
        eng_a   = AM'(acc_mag);
        eng_neg = acc_tot_q[AW-1];
        eng_b   = {1'b0, per_eff};
      end
      ST_SLIP: begin
        eng_a   = dvw_mag[AM-1:0];
        eng_neg = dvw[AM];
        eng_b   = K_THOU;
        eng_c   = v_q[AM-1:0];
      end
      ST_RATE: begin
        eng_a   = AM'(dsl_mag);
        eng_neg = dsl[32];
        eng_c   = AM'(per_eff);
      end
      ST_R0A, ST_R1A: begin
        eng_a   = AM'(rv_mag);
        eng_neg = rv[11];
        eng_b   = ma_q;
        eng_div = 1'b0;
      end
      ST_R0B, ST_R1B: begin
        eng_a   = AM'(rv_mag);
        eng_neg = rv[11];
        eng_b   = K_THOU - ma_q;
        eng_div = 1'b0;
      end
      ST_N0: begin
        eng_a   = AM'(row_mag);
        eng_neg = row_q[20];
        eng_b   = me_q;
      end
      ST_N1: begin
        eng_a   = AM'(row_mag);
        eng_neg = row_q[20];
        eng_b   = K_THOU - me_q;
      end
      ST_FIN: begin
        eng_a   = AM'(n_mag);
        eng_neg = n_q[20];
      end
      default: begin
        eng_div = 1'b1;
      end
    endcase
  end

  assign eng_start = !iss_q && st_q != ST_IDLE && st_q != ST_OUT;

  fasc_muldiv #(
    .AM (AM),
    .PW (PW)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (eng_start),
    .a_i     (eng_a),
    .b_i     (eng_b),
    .c_i     (eng_c),
    .neg_i   (eng_neg),
    .div_i   (eng_div),
    .done_o  (eng_done),
    .res_o   (eng_res)
  );

  assign out_load = (st_q == ST_OUT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      iss_q       <= 1'b0;
      acc_tot_q   <= '0;
      base_q      <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (eng_start) begin
        iss_q <= 1'b1;
      end else if (eng_done) begin
        iss_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: begin
          if (in_xfer) begin
            acc_tot_q <= acc_next;
            st_q      <= ST_WT;
          end
        end
        ST_WT: begin
          if (eng_done) begin
            if (!prs_q) begin
              base_q <= eng_res[18:0];
              prev_q <= '0;
              st_q   <= ST_OUT;
            end else begin
              st_q <= ST_V;
            end
          end
        end
        ST_V: begin
          if (eng_done) begin
            st_q <= (v_new <= 0) ? ST_RATE : ST_SLIP;
          end
        end
        ST_SLIP: begin
          if (eng_done) begin
            st_q <= ST_RATE;
          end
        end
        ST_RATE: begin
          if (eng_done) begin
            prev_q <= slip_q;
            st_q   <= ST_R0A;
          end
        end
        ST_R0A: if (eng_done) st_q <= ST_R0B;
        ST_R0B: if (eng_done) st_q <= ST_N0;
        ST_N0:  if (eng_done) st_q <= ST_R1A;
        ST_R1A: if (eng_done) st_q <= ST_R1B;
        ST_R1B: if (eng_done) st_q <= ST_N1;
        ST_N1:  if (eng_done) st_q <= ST_FIN;
        ST_FIN: if (eng_done) st_q <= ST_OUT;
        ST_OUT: begin
          if (out_load) begin
            st_q <= ST_IDLE;
          end
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ws_q  <= wheel_speed_i;
      prs_q <= brake_pressed_i;
    end
    if (out_load) begin
      out_drv_q <= drv_q;
      out_flt_q <= flt_q;
    end
    if (eng_done) begin
      case (st_q)
        ST_WT: begin
          w_q <= eng_res[18:0];
          if (!prs_q) begin
            drv_q <= DRIVE_RELEASE;
            flt_q <= 1'b0;
          end
        end
        ST_V: begin
          v_q <= v_new;
          if (v_new <= 0) begin
            flt_q  <= 1'b1;
            slip_q <= '0;
          end else begin
            flt_q <= 1'b0;
          end
        end
        ST_SLIP: slip_q <= eng_res[31:0];
        ST_RATE: begin
          ka_q <= seg_r.k;
          ma_q <= seg_r.m;
          ke_q <= seg_e.k;
          me_q <= seg_e.m;
        end
        ST_R0A, ST_R1A: t_q   <= eng_res[20:0];
        ST_R0B, ST_R1B: row_q <= t_q + eng_res[20:0];
        ST_N0:          n_q   <= eng_res[20:0];
        ST_N1:          n_q   <= n_q + eng_res[20:0];
        ST_FIN:         drv_q <= eng_res[10:0];
        default: begin
          t_q <= t_q;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign modulator_drive_o = out_drv_q;
  assign speed_fault_o     = out_flt_q;

endmodule

/* hw/rtl/fasc_checker.sv */
// ----------------------------------------------------------------------------
// fasc_checker
// Port-level checks for the slip controller, bound to the top level.
// ----------------------------------------------------------------------------
module fasc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [1:0]         cfg_idx_i,
  input logic [9:0]         cfg_wdata_i,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [17:0]        wheel_speed_i,
  input logic signed [15:0] vehicle_accel_i,
  input logic               brake_pressed_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [10:0] modulator_drive_o,
  input logic               speed_fault_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(modulator_drive_o) && $stable(speed_fault_o))
    else $error("stalled result changed");

  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (modulator_drive_o >= -11'sd1000) && (modulator_drive_o <= 11'sd1000))
    else $error("drive out of range");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transfer taken while busy");

endmodule

bind fuzzy_abs_slip_controller fasc_checker u_fasc_checker (.*);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fuzzy slip controller. A driver process moves
// queued control ticks into the block with random gaps; every accepted tick
// is run through a local slip/fuzzy predictor and the expected command is
// queued. A monitor process compares each result transfer against the
// oldest expectation while the result side stalls at random, once for a
// long stretch. Register settings change between phases, extremes included.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fasc_pkg::*;

  localparam longint CycleLimit = 5000000;

  typedef struct {
    logic [17:0]        ws;
    logic signed [15:0] acc;
    logic               pressed;
  } tick_t;

  typedef struct {
    logic signed [10:0] drive;
    logic               fault;
  } cmd_t;

  localparam int Rules[7][7] = '{
    '{1000, 1000, 1000, 1000, 667, 333, 0},
    '{1000, 1000, 1000, 667, 667, 0, -333},
    '{1000, 667, 667, 333, 0, -333, -667},
    '{1000, 667, 333, 0, -333, -667, -1000},
    '{667, 333, 0, -333, -667, -667, -1000},
    '{333, 0, -667, -667, -1000, -1000, -1000},
    '{0, -333, -667, -1000, -1000, -1000, -1000}};

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = '0;
  logic [9:0]         cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [17:0]        wheel_speed_i = '0;
  logic signed [15:0] vehicle_accel_i = '0;
  logic               brake_pressed_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [10:0] modulator_drive_o;
  logic               speed_fault_o;

  fuzzy_abs_slip_controller dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  tick_t  pending_ticks[$];
  cmd_t   expected_cmds[$];
  int     errors = 0;
  int     n_results = 0;
  bit     no_idle = 1'b0;
  longint cycles = 0;

  // Predictor state and register copies
  longint m_target = 150, m_period = 20, m_radius = 250;
  longint m_prev_slip = 0, m_base = 0, m_accsum = 0;

  function automatic longint member(int s, longint x);
    case (s)
      0: return (x <= -1000) ? 1000 : (x < -500) ? -2 * x - 1000 : 0;
      1: return (x <= -1000) ? 0 : (x <= -500) ? 2 * x + 2000 :
                (x < -250) ? -4 * x - 1000 : 0;
      2: return (x <= -500) ? 0 : (x <= -250) ? 4 * x + 2000 : (x < 0) ? -4 * x : 0;
      3: return (x <= -250) ? 0 : (x <= 0) ? 4 * x + 1000 :
                (x < 250) ? -4 * x + 1000 : 0;
      4: return (x <= 0) ? 0 : (x <= 250) ? 4 * x : (x < 500) ? -4 * x + 2000 : 0;
      5: return (x <= 250) ? 0 : (x <= 500) ? 4 * x - 1000 :
                (x < 1000) ? -2 * x + 2000 : 0;
      default: return (x <= 500) ? 0 : (x < 1000) ? 2 * x - 1000 : 1000;
    endcase
  endfunction

  function automatic longint fuzzy_command(longint err, longint rate);
    longint mr[7];
    longint rsum, num, den, me, row;
    rsum = 0; num = 0; den = 0;
    for (int j = 0; j < 7; j++) begin
      mr[j] = member(j, rate);
      rsum += mr[j];
    end
    for (int i = 0; i < 7; i++) begin
      me = member(i, err);
      row = 0;
      for (int j = 0; j < 7; j++) row += mr[j] * Rules[i][j];
      num += me * row / 1000;
      den += me * rsum / 1000;
    end
    return (den == 0) ? 0 : num / den;
  endfunction

  function automatic cmd_t predict_cmd(tick_t t);
    cmd_t   c;
    longint per, wterm, a, v, slip, drv;
    per = (m_period == 0) ? 1 : m_period;
    wterm = longint'(t.ws) * m_radius / 1000;
    a = longint'(t.acc);
    c.fault = 1'b0;
    if (!t.pressed) begin
      m_base = wterm;
      m_accsum = a;
      m_prev_slip = 0;
      drv = -1000;
    end else begin
      m_accsum += a;
      if (m_accsum > 64'sd2147483647) m_accsum = 64'sd2147483647;
      if (m_accsum < -64'sd2147483648) m_accsum = -64'sd2147483648;
      v = m_accsum * per / 1000 + m_base;
      if (v <= 0) begin
        slip = 0;
        c.fault = 1'b1;
      end else begin
        slip = (v - wterm) * 1000 / v;
      end
      drv = fuzzy_command(slip - m_target, (slip - m_prev_slip) / per);
      m_prev_slip = slip;
    end
    c.drive = 11'(drv);
    return c;
  endfunction

  function automatic int pick_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    return $urandom_range(3, 10);
  endfunction

  // Driver
  int    in_gap = 0;
  tick_t cur;
  always @(posedge clk_i) begin
    bit nv;
    if (rst_ni) begin
      nv = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        expected_cmds.push_back(predict_cmd(cur));
        nv = 1'b0;
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_ticks.size() > 0) begin
          cur = pending_ticks.pop_front();
          wheel_speed_i <= cur.ws;
          vehicle_accel_i <= cur.acc;
          brake_pressed_i <= cur.pressed;
          nv = 1'b1;
          in_gap = pick_gap();
        end
      end
      in_valid_i <= nv;
    end
  end

  // Long hold-off of the result side
  int hold_cnt = 0;
  bit held = 1'b0;
  always @(posedge clk_i) begin
    if (n_results == 300 && !held) begin
      held <= 1'b1;
      hold_cnt <= 3000;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, n_results);
    errors++;
  endtask

  // Monitor
  int   out_gap = 0;
  cmd_t want;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_cmds.size() == 0) begin
          report("unexpected result", modulator_drive_o, 0);
        end else begin
          want = expected_cmds.pop_front();
          if (modulator_drive_o !== want.drive)
            report("modulator_drive", modulator_drive_o, want.drive);
          if (speed_fault_o !== want.fault)
            report("speed_fault", speed_fault_o, want.fault);
        end
        n_results++;
      end
      if (hold_cnt > 0) begin
        out_ready_i <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("fuzzy_abs_slip_controller regression: fail");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_ticks.size() > 0 || in_valid_i || expected_cmds.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_SLIP_TARGET:  m_target = val;
      CFG_TICK_PERIOD:  m_period = val;
      default:          m_radius = val;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(int tgt, int per, int rad);
    wait_idle();
    write_reg(CFG_SLIP_TARGET, 10'(tgt));
    write_reg(CFG_TICK_PERIOD, 10'(per));
    write_reg(CFG_WHEEL_RADIUS, 10'(rad));
  endtask

  task automatic add_tick(int ws, int acc, bit pr);
    tick_t t;
    t.ws = 18'(ws);
    t.acc = 16'(acc);
    t.pressed = pr;
    pending_ticks.push_back(t);
  endtask

  // Braking run: release, then pressed ticks no faster than the release tick
  task automatic add_stop(output int cnt);
    int ws0, n, frac, ws;
    ws0 = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 262143) : $urandom_range(0, 120000);
    add_tick(ws0, $urandom_range(0, 65535), 1'b0);
    n = $urandom_range(3, 12);
    for (int k = 0; k < n; k++) begin
      frac = $urandom_range(0, 1100);
      ws = (frac >= 1000) ? 0 : ws0 - ws0 / 1000 * frac;
      add_tick(ws, -$urandom_range(0, 12000) + $urandom_range(0, 2000), 1'b1);
    end
    cnt = n + 1;
  endtask

  task automatic add_random(int count);
    int made, got;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 99) < 15) begin
        add_tick($urandom_range(0, 262143), $urandom_range(0, 65535), $urandom_range(0, 1));
        made++;
      end else begin
        add_stop(got);
        made += got;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_regs(150, 20, 250);
    add_tick(0, 0, 1'b0);
    add_tick(0, 0, 1'b1);
    add_tick(262143, 32767, 1'b0);
    add_tick(262143, 32767, 1'b1);
    add_tick(0, -32768, 1'b1);
    add_tick(100000, 0, 1'b0);
    add_tick(100000, 0, 1'b1);
    add_tick(85000, -500, 1'b1);
    add_tick(40000, -9000, 1'b1);
    add_tick(0, -2000, 1'b1);
    add_tick(10, -32768, 1'b0);
    add_tick(0, -32768, 1'b1);
    add_tick(262143, 0, 1'b1);
    add_tick(50000, -1, 1'b0);
    add_tick(49000, 32767, 1'b1);
    set_regs(0, 1, 1);
    add_random(100);
    no_idle = 1'b1;
    set_regs(1000, 1000, 1000);
    add_random(100);
    no_idle = 1'b0;
    set_regs(150, 0, 250);
    add_random(100);
    set_regs(1000, 1, 1000);
    add_random(100);
    set_regs(0, 1000, 1);
    add_random(100);
    for (int p = 0; p < 9; p++) begin
      no_idle = (p % 3 == 2);
      set_regs($urandom_range(0, 1000), $urandom_range(1, 1000), $urandom_range(1, 1000));
      add_random(95);
    end
    no_idle = 1'b0;
    wait_idle();
    repeat (600) @(posedge clk_i);
    if (errors == 0 && expected_cmds.size() == 0)
      $display("fuzzy_abs_slip_controller regression: pass");
    else
      $display("fuzzy_abs_slip_controller regression: fail");
    $finish;
  end

endmodule
